// ===== design/case_insensitive_pattern_counter_defines.svh =====
// ----------------------------------------------------------------------------
// case insensitive pattern counter assertion macros
// shared property forms for the pattern counter checks
// ----------------------------------------------------------------------------
`ifndef CASE_INSENSITIVE_PATTERN_COUNTER_DEFINES_SVH
`define CASE_INSENSITIVE_PATTERN_COUNTER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define CIPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define CIPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cipc_pkg.sv =====
// ----------------------------------------------------------------------------
// cipc_pkg
// types, codes and helpers shared by the pattern counter modules
// ----------------------------------------------------------------------------
`default_nettype none

package cipc_pkg;

    localparam int unsigned LEN_W   = 5;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 64;

    localparam logic [7:0]         NEWLINE = 8'd10;
    localparam logic [VALUE_W-1:0] SAT32   = {VALUE_W{1'b1}};

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    typedef enum logic {
        KIND_LINE  = 1'b0,
        KIND_TOTAL = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               final_result;
    } result_t;

    // up to two results written into the result queue per request
    typedef struct packed {
        logic [1:0] cnt;
        result_t    e0;
        result_t    e1;
    } push_t;

    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'd65 && b <= 8'd90) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/cipc_window.sv =====
// ----------------------------------------------------------------------------
// cipc_window
// folded byte window, boundary counter and parallel pattern compare
// ----------------------------------------------------------------------------
`default_nettype none

module cipc_window #(
    parameter int unsigned MAX_PATTERN = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire logic [7:0]                 text_byte,
    input  wire logic                       restart,   // newline or end of text
    input  wire logic                       clear,     // end of text
    input  wire logic [127:0]               pattern,
    input  wire logic [cipc_pkg::LEN_W-1:0] len,       // already clamped 1..MAX_PATTERN
    output logic                            hit
);

    localparam int unsigned CW = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN-1:0][7:0] win_reg;
    logic [MAX_PATTERN-1:0][7:0] win_next;
    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               cnt_inc;
    logic [CW-1:0]               cnt_next;
    logic [MAX_PATTERN-1:0]      lane_ok;

    always_comb begin
        win_next[0] = cipc_pkg::fold(text_byte);
        for (int j = 1; j < MAX_PATTERN; j++) begin
            win_next[j] = win_reg[j-1];
        end
    end

    assign cnt_inc = (cnt_reg == CW'(MAX_PATTERN)) ? cnt_reg : cnt_reg + CW'(1);

    // lane j holds the byte j places back; it meets pattern byte len-1-j
    always_comb begin
        logic [cipc_pkg::LEN_W-1:0] pidx;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pidx = len - cipc_pkg::LEN_W'(1) - cipc_pkg::LEN_W'(j);
            lane_ok[j] = (cipc_pkg::LEN_W'(j) >= len) ||
                         (win_next[j] == cipc_pkg::fold(pattern[{pidx[3:0], 3'b000} +: 8]));
        end
    end

    assign hit = (&lane_ok) && (cipc_pkg::LEN_W'(cnt_inc) >= len);

    always_comb begin
        cnt_next = cnt_inc;
        if (hit || restart) begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
            cnt_reg <= '0;
        end else if (advance) begin
            win_reg <= clear ? '0 : win_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/cipc_rfifo.sv =====
// ----------------------------------------------------------------------------
// cipc_rfifo
// four-entry result queue, takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
`default_nettype none

module cipc_rfifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cipc_pkg::push_t   push,
    input  wire logic              pop,
    output cipc_pkg::result_t      head,
    output logic                   not_empty,
    output logic                   has_room    // room for two more results
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW    = $clog2(DEPTH);

    cipc_pkg::result_t mem [DEPTH];
    logic [PW-1:0]     wr_reg;
    logic [PW-1:0]     rd_reg;
    logic [PW:0]       cnt_reg;
    logic [PW:0]       cnt_next;
    logic              do_pop;

    assign not_empty = (cnt_reg != '0);
    assign has_room  = (cnt_reg <= (PW+1)'(DEPTH - 2));
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_reg];
    assign cnt_next  = cnt_reg + (PW+1)'(push.cnt) - (PW+1)'(do_pop);

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_reg] <= push.e0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_reg + PW'(1)] <= push.e1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + PW'(push.cnt);
            rd_reg  <= rd_reg + PW'(do_pop);
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/case_insensitive_pattern_counter.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_pattern_counter
// counts non-overlapping case-folded pattern matches in a byte stream,
// reports matching line numbers and the total count at end of text
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata[7:0] text_byte, s_tlast end_of_text
//  m_        out  m_tvalid/m_tready  m_tdata result_value, m_tuser result_kind,
//                                    m_tlast final_result
//  cfg_      in   cfg_we             cfg_index, cfg_wdata
//
//  one text byte per cycle; the window compare and counter update sit between
//  the state registers and a four-entry result queue
//  a byte ending a matching line together with end of text makes two results,
//  which drain one per cycle through the queue while m_tready is high
//  s_tready drops while the queue has room for fewer than two results
//  aresetn is synchronous; it clears all state and sets the pattern length to 1
// ----------------------------------------------------------------------------
`default_nettype none

`include "case_insensitive_pattern_counter_defines.svh"

module case_insensitive_pattern_counter #(
    parameter int unsigned MAX_PATTERN = 16,
    parameter int unsigned LIST_LIMIT  = 1024
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] text_byte
    input  wire logic                         s_tlast,   // end_of_text

    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [cipc_pkg::VALUE_W-1:0]      m_tdata,   // [31:0] result_value
    output logic                              m_tuser,   // [0] result_kind
    output logic                              m_tlast,   // final_result

    input  wire logic                         cfg_we,
    input  wire logic [cipc_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [cipc_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int unsigned RW = $clog2(LIST_LIMIT + 1);
    localparam int unsigned VW = cipc_pkg::VALUE_W;
    localparam int unsigned LW = cipc_pkg::LEN_W;

    logic [63:0]   pat_lo_reg;
    logic [63:0]   pat_hi_reg;
    logic [LW-1:0] pat_len_reg;
    logic [LW-1:0] len;

    logic [VW-1:0] line_reg;
    logic [VW-1:0] line_next;
    logic          had_reg;
    logic          had_next;
    logic [VW-1:0] total_reg;
    logic [VW-1:0] total_next;
    logic [VW-1:0] total_inc;
    logic [RW-1:0] rep_reg;
    logic [RW-1:0] rep_next;

    logic              acc;
    logic              is_nl;
    logic              line_end;
    logic              hit;
    logic              report_line;
    cipc_pkg::push_t   push;
    cipc_pkg::result_t head;
    logic              room;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= LW'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                cipc_pkg::REG_PATTERN_LOW:    pat_lo_reg  <= cfg_wdata;
                cipc_pkg::REG_PATTERN_HIGH:   pat_hi_reg  <= cfg_wdata;
                cipc_pkg::REG_PATTERN_LENGTH: pat_len_reg <= cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        len = pat_len_reg;
        if (pat_len_reg == '0) begin
            len = LW'(1);
        end else if (pat_len_reg > LW'(MAX_PATTERN)) begin
            len = LW'(MAX_PATTERN);
        end
    end

    assign acc      = s_tvalid && s_tready;
    assign is_nl    = (s_tdata == cipc_pkg::NEWLINE);
    assign line_end = is_nl || s_tlast;

    cipc_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (acc),
        .text_byte (s_tdata),
        .restart   (line_end),
        .clear     (s_tlast),
        .pattern   ({pat_hi_reg, pat_lo_reg}),
        .len       (len),
        .hit       (hit)
    );

    assign total_inc   = (hit && total_reg != cipc_pkg::SAT32) ? total_reg + VW'(1) : total_reg;
    assign report_line = line_end && (had_reg || hit) && (rep_reg < RW'(LIST_LIMIT));

    always_comb begin
        line_next  = line_reg;
        had_next   = had_reg || hit;
        total_next = total_inc;
        rep_next   = rep_reg;
        if (s_tlast) begin
            line_next  = VW'(1);
            had_next   = 1'b0;
            total_next = '0;
            rep_next   = '0;
        end else if (line_end) begin
            if (line_reg != cipc_pkg::SAT32) begin
                line_next = line_reg + VW'(1);
            end
            had_next = 1'b0;
            rep_next = rep_reg + RW'(report_line);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg  <= VW'(1);
            had_reg   <= 1'b0;
            total_reg <= '0;
            rep_reg   <= '0;
        end else if (acc) begin
            line_reg  <= line_next;
            had_reg   <= had_next;
            total_reg <= total_next;
            rep_reg   <= rep_next;
        end
    end

    // line report goes first, total count after it
    always_comb begin
        cipc_pkg::result_t line_res;
        cipc_pkg::result_t total_res;
        line_res.kind          = cipc_pkg::KIND_LINE;
        line_res.value         = line_reg;
        line_res.final_result  = 1'b0;
        total_res.kind         = cipc_pkg::KIND_TOTAL;
        total_res.value        = total_inc;
        total_res.final_result = 1'b1;
        push.cnt = '0;
        if (acc) begin
            push.cnt = 2'(report_line) + 2'(s_tlast);
        end
        push.e0 = report_line ? line_res : total_res;
        push.e1 = total_res;
    end

    cipc_rfifo u_rfifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_tready),
        .head      (head),
        .not_empty (m_tvalid),
        .has_room  (room)
    );

    assign s_tready = room;
    assign m_tdata  = head.value;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.final_result;

    `CIPC_ASSERT_NEXT(a_total_follows_last, s_tvalid && s_tready && s_tlast, m_tvalid,
        "end of text request left no result pending")
    `CIPC_ASSERT_NEXT(a_state_cleared_after_last, s_tvalid && s_tready && s_tlast,
        total_reg == '0 && line_reg == VW'(1) && rep_reg == '0 && !had_reg,
        "state not cleared after end of text")
    `CIPC_ASSERT_NOW(a_report_limit, 1'b1, rep_reg <= RW'(LIST_LIMIT),
        "reported line count passed the limit")

endmodule

`default_nettype wire
